// ===== hdl/scancode_to_char_fifo_assert.svh =====
// Assertion macros shared by the checker of scancode_to_char_fifo.
// Needs clk and rst in the scope where a macro is used.
`ifndef SCANCODE_TO_CHAR_FIFO_ASSERT_SVH
`define SCANCODE_TO_CHAR_FIFO_ASSERT_SVH

// same-cycle implication, off during reset
`define SCTC_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define SCTC_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

// next-cycle implication, always on
`define SCTC_ASSERT_ALWAYS(lbl, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== hdl/sctc_pkg.sv =====
// Types, codes and the character ROM of the scan code decoder.
// No dependencies.
package sctc_pkg;

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [7:0] SC_PREFIX     = 8'hE0;
  localparam logic [7:0] SC_UP         = 8'h48;
  localparam logic [7:0] SC_DOWN       = 8'h50;
  localparam logic [7:0] SC_CTRL_MAKE  = 8'h1D;
  localparam logic [7:0] SC_CTRL_BREAK = 8'h9D;
  localparam logic [7:0] TOKEN_UP      = 8'hE0;
  localparam logic [7:0] TOKEN_DOWN    = 8'hE1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] scan_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic       ctrl_held;
    logic [7:0] last_key;
  } result_t;

  typedef struct packed {
    logic       push;
    logic [7:0] push_char;
    logic       pop;
  } queue_cmd_t;

  typedef struct packed {
    queue_cmd_t cmd;
    logic       prefix_next;
    logic       ctrl_next;
    logic [7:0] last_next;
  } decode_t;

  function automatic logic [7:0] char_rom(input logic [6:0] code);
    logic [7:0] ch;
    case (code)
      7'd1:  ch = 8'd27;
      7'd2:  ch = 8'h31;
      7'd3:  ch = 8'h32;
      7'd4:  ch = 8'h33;
      7'd5:  ch = 8'h34;
      7'd6:  ch = 8'h35;
      7'd7:  ch = 8'h36;
      7'd8:  ch = 8'h37;
      7'd9:  ch = 8'h38;
      7'd10: ch = 8'h39;
      7'd11: ch = 8'h30;
      7'd12: ch = 8'h2D;
      7'd13: ch = 8'h3D;
      7'd14: ch = 8'd8;
      7'd15: ch = 8'd9;
      7'd16: ch = 8'h71;
      7'd17: ch = 8'h77;
      7'd18: ch = 8'h65;
      7'd19: ch = 8'h72;
      7'd20: ch = 8'h74;
      7'd21: ch = 8'h79;
      7'd22: ch = 8'h75;
      7'd23: ch = 8'h69;
      7'd24: ch = 8'h6F;
      7'd25: ch = 8'h70;
      7'd26: ch = 8'h5B;
      7'd27: ch = 8'h5D;
      7'd28: ch = 8'd10;
      7'd30: ch = 8'h61;
      7'd31: ch = 8'h73;
      7'd32: ch = 8'h64;
      7'd33: ch = 8'h66;
      7'd34: ch = 8'h67;
      7'd35: ch = 8'h68;
      7'd36: ch = 8'h6A;
      7'd37: ch = 8'h6B;
      7'd38: ch = 8'h6C;
      7'd39: ch = 8'h3B;
      7'd40: ch = 8'd39;
      7'd41: ch = 8'h60;
      7'd43: ch = 8'd92;
      7'd44: ch = 8'h7A;
      7'd45: ch = 8'h78;
      7'd46: ch = 8'h63;
      7'd47: ch = 8'h76;
      7'd48: ch = 8'h62;
      7'd49: ch = 8'h6E;
      7'd50: ch = 8'h6D;
      7'd51: ch = 8'h2C;
      7'd52: ch = 8'h2E;
      7'd53: ch = 8'h2F;
      7'd55: ch = 8'h2A;
      7'd57: ch = 8'h20;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== hdl/sctc_decode.sv =====
// Decode of one item: prefix and control tracking, ROM lookup, queue command.
// Depends on sctc_pkg.
module sctc_decode (
  input  sctc_pkg::item_t   item,
  input  logic              prefix_seen,
  input  logic              ctrl_flag,
  input  logic [7:0]        last_char,
  output sctc_pkg::decode_t dec
);

  logic [7:0] ch;

  assign ch = sctc_pkg::char_rom(item.scan_byte[6:0]);

  always_comb begin
    dec.cmd.push      = 1'b0;
    dec.cmd.push_char = ch;
    dec.cmd.pop       = 1'b0;
    dec.prefix_next   = prefix_seen;
    dec.ctrl_next     = ctrl_flag;
    dec.last_next     = last_char;
    if (item.opcode == sctc_pkg::OP_READ) begin
      dec.cmd.pop = 1'b1;
    end else if (item.scan_byte == sctc_pkg::SC_PREFIX) begin
      dec.prefix_next = 1'b1;
    end else begin
      dec.prefix_next = 1'b0;
      if (prefix_seen && item.scan_byte == sctc_pkg::SC_UP) begin
        dec.cmd.push      = 1'b1;
        dec.cmd.push_char = sctc_pkg::TOKEN_UP;
      end else if (prefix_seen && item.scan_byte == sctc_pkg::SC_DOWN) begin
        dec.cmd.push      = 1'b1;
        dec.cmd.push_char = sctc_pkg::TOKEN_DOWN;
      end else begin
        if (item.scan_byte == sctc_pkg::SC_CTRL_MAKE) begin
          dec.ctrl_next = 1'b1;
        end else if (item.scan_byte == sctc_pkg::SC_CTRL_BREAK) begin
          dec.ctrl_next = 1'b0;
        end
        if (!item.scan_byte[7] && ch != 8'h00) begin
          dec.cmd.push  = 1'b1;
          dec.last_next = ch;
        end
      end
    end
  end

endmodule

// ===== hdl/sctc_queue.sv =====
// Ring queue of characters with registered read data; drops pushes when full.
// Depends on sctc_pkg.
module sctc_queue #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  sctc_pkg::queue_cmd_t cmd,
  output logic [7:0]           read_char
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_INDEX = AW'(QUEUE_DEPTH - 1);

  logic [7:0]    mem [QUEUE_DEPTH];
  logic [AW-1:0] write_index;
  logic [AW-1:0] read_index;
  logic [AW-1:0] write_index_next;
  logic [AW-1:0] read_index_next;
  logic          full;
  logic          empty;
  logic          do_push;
  logic          do_pop;

  assign write_index_next = (write_index == LAST_INDEX) ? '0 : write_index + 1'b1;
  assign read_index_next  = (read_index == LAST_INDEX) ? '0 : read_index + 1'b1;
  assign full    = (write_index_next == read_index);
  assign empty   = (write_index == read_index);
  assign do_push = en && cmd.push && !full;
  assign do_pop  = en && cmd.pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[write_index] <= cmd.push_char;
    end
    if (en) begin
      read_char <= do_pop ? mem[read_index] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
    end else begin
      if (do_push) begin
        write_index <= write_index_next;
      end
      if (do_pop) begin
        read_index <= read_index_next;
      end
    end
  end

endmodule

// ===== hdl/scancode_to_char_fifo.sv =====
// Each item passes through the input register and then the result register before its result beat.
// Throughput: 1 item per cycle while results are taken; an empty input register takes a beat while a result waits.
// Queue read and write each use one port of the character memory in the same cycle.
// Reset: synchronous; clears prefix, control, last key, queue pointers and valids.
// Queue contents are not cleared; the queue holds QUEUE_DEPTH-1 characters.
// Depends on sctc_pkg, sctc_decode, sctc_queue.
module scancode_to_char_fifo #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  sctc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output sctc_pkg::result_t result
);

  sctc_pkg::item_t   held;
  logic              held_valid;
  logic              advance;
  logic              prefix_seen;
  logic              ctrl_flag;
  logic [7:0]        last_char;
  logic [7:0]        read_char;
  sctc_pkg::decode_t dec;

  assign advance    = held_valid && (!result_valid || result_ready);
  assign item_ready = !held_valid || advance;

  sctc_decode u_decode (
    .item        (held),
    .prefix_seen (prefix_seen),
    .ctrl_flag   (ctrl_flag),
    .last_char   (last_char),
    .dec         (dec)
  );

  sctc_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .cmd       (dec.cmd),
    .read_char (read_char)
  );

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
      prefix_seen  <= 1'b0;
      ctrl_flag    <= 1'b0;
      last_char    <= 8'h00;
    end else begin
      if (item_ready) begin
        held_valid <= item_valid;
      end
      if (advance) begin
        result_valid <= 1'b1;
        prefix_seen  <= dec.prefix_next;
        ctrl_flag    <= dec.ctrl_next;
        last_char    <= dec.last_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign result.read_char = read_char;
  assign result.ctrl_held = ctrl_flag;
  assign result.last_key  = last_char;

endmodule

// ===== hdl/sctc_checker.sv =====
// Port-level checks of scancode_to_char_fifo, bound to the top level.
// Depends on sctc_pkg and scancode_to_char_fifo_assert.svh.
`include "scancode_to_char_fifo_assert.svh"

module sctc_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input sctc_pkg::result_t result
);

  `SCTC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))
  `SCTC_ASSERT_ALWAYS(a_reset_clear, rst, !result_valid && item_ready)
  `SCTC_ASSERT_NOW(a_empty_takes, !result_valid, item_ready)
  `SCTC_ASSERT_NOW(a_stall_cause, !item_ready, result_valid && !result_ready)

endmodule

bind scancode_to_char_fifo sctc_checker u_sctc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// ===== test/scancode_to_char_fifo_checker.sv =====
// Checker for scancode_to_char_fifo: watches the item and result channels, predicts
// each result from its own copy of the decoder state and compares field by field.
// Depends on sctc_pkg for the beat types and the scan code constants.
`timescale 1ns / 1ps

module scancode_to_char_fifo_checker #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  sctc_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_ready,
  input  sctc_pkg::result_t result,
  output int                errors,
  output int                outstanding
);

  localparam logic [7:0] KEYMAP [0:57] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  logic              prefix_armed;
  logic              ctrl_down;
  logic [7:0]        last_seen;
  logic [7:0]        char_mem [QUEUE_DEPTH];
  int                wr_ptr;
  int                rd_ptr;
  sctc_pkg::result_t expected_results [$];

  initial errors = 0;

  function automatic logic [7:0] map_code(input logic [6:0] code);
    int idx;
    idx = int'(code);
    return (idx <= 57) ? KEYMAP[idx] : 8'h00;
  endfunction

  function automatic void enqueue_char(input logic [7:0] ch);
    int nxt;
    nxt = (wr_ptr + 1) % QUEUE_DEPTH;
    if (nxt != rd_ptr) begin
      char_mem[wr_ptr] = ch;
      wr_ptr = nxt;
    end
  endfunction

  function automatic sctc_pkg::result_t decode_key(input sctc_pkg::item_t it);
    sctc_pkg::result_t r;
    logic [7:0]        code;
    logic [7:0]        ch;
    logic              arrow;
    r = '0;
    code = it.scan_byte;
    arrow = 1'b0;
    if (it.opcode == sctc_pkg::OP_READ) begin
      if (rd_ptr != wr_ptr) begin
        r.read_char = char_mem[rd_ptr];
        rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
      end
    end else if (code == sctc_pkg::SC_PREFIX) begin
      prefix_armed = 1'b1;
    end else begin
      if (prefix_armed) begin
        prefix_armed = 1'b0;
        if (code == sctc_pkg::SC_UP) begin
          enqueue_char(sctc_pkg::TOKEN_UP);
          arrow = 1'b1;
        end else if (code == sctc_pkg::SC_DOWN) begin
          enqueue_char(sctc_pkg::TOKEN_DOWN);
          arrow = 1'b1;
        end
      end
      if (!arrow) begin
        if (code == sctc_pkg::SC_CTRL_MAKE) ctrl_down = 1'b1;
        else if (code == sctc_pkg::SC_CTRL_BREAK) ctrl_down = 1'b0;
        if (!code[7]) begin
          ch = map_code(code[6:0]);
          if (ch != 8'h00) begin
            last_seen = ch;
            enqueue_char(ch);
          end
        end
      end
    end
    r.ctrl_held = ctrl_down;
    r.last_key  = last_seen;
    return r;
  endfunction

  task automatic report(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    sctc_pkg::result_t want;
    if (rst) begin
      prefix_armed = 1'b0;
      ctrl_down    = 1'b0;
      last_seen    = 8'h00;
      wr_ptr       = 0;
      rd_ptr       = 0;
      expected_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          report($sformatf("result beat %h with nothing expected", result));
        end else begin
          want = expected_results.pop_front();
          if (result.read_char !== want.read_char)
            report($sformatf("read_char %h, want %h", result.read_char, want.read_char));
          if (result.ctrl_held !== want.ctrl_held)
            report($sformatf("ctrl_held %b, want %b", result.ctrl_held, want.ctrl_held));
          if (result.last_key !== want.last_key)
            report($sformatf("last_key %h, want %h", result.last_key, want.last_key));
        end
      end
      if (item_valid && item_ready)
        expected_results.push_back(decode_key(item));
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the scancode_to_char_fifo testbench: clock, reset, stimulus and verdict.
// Depends on sctc_pkg, the block and scancode_to_char_fifo_checker.
`timescale 1ns / 1ps

module testbench;

  typedef enum int {FILL, DRAIN, MIX} traffic_t;

  localparam int ITEM_TARGET = 1600;
  localparam int QUIET_LIMIT = 1000;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_ready;
  sctc_pkg::item_t   item         = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  sctc_pkg::result_t result;
  int                errors;
  int                outstanding;
  bit                no_idle      = 1'b0;
  int                stall_left   = 0;
  int                quiet_cycles = 0;
  int                sent         = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  scancode_to_char_fifo u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  scancode_to_char_fifo_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  // hold ready low for a drawn number of cycles after each result beat
  always @(posedge clk) begin
    int draw;
    if (rst) begin
      result_ready <= 1'b0;
      stall_left   <= 0;
    end else if (result_valid && result_ready) begin
      draw = no_idle ? 0 : $urandom_range(0, 3);
      stall_left   <= draw;
      result_ready <= (draw == 0);
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      result_ready <= (stall_left == 1);
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("** scancode_to_char_fifo: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input sctc_pkg::item_t beat);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= beat;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sent++;
  endtask

  task automatic press(input logic [7:0] code);
    sctc_pkg::item_t beat;
    beat.opcode    = sctc_pkg::OP_SCAN;
    beat.scan_byte = code;
    send_item(beat);
  endtask

  task automatic pop_char();
    sctc_pkg::item_t beat;
    beat.opcode    = sctc_pkg::OP_READ;
    beat.scan_byte = 8'($urandom_range(0, 255));
    send_item(beat);
  endtask

  task automatic send_random_scan();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      press(8'($urandom_range(1, 57)));
    end else if (pick < 65) begin
      press(sctc_pkg::SC_PREFIX);
      press($urandom_range(0, 1) ? sctc_pkg::SC_UP : sctc_pkg::SC_DOWN);
    end else if (pick < 75) begin
      press(sctc_pkg::SC_PREFIX);
      press(8'($urandom_range(0, 255)));
    end else if (pick < 85) begin
      press($urandom_range(0, 1) ? sctc_pkg::SC_CTRL_MAKE : sctc_pkg::SC_CTRL_BREAK);
    end else begin
      press(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    traffic_t kind;
    int       span;
    int       stop;
    int       read_pct;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    pop_char();
    press(8'h00);
    press(8'hFF);
    press(8'h7F);
    press(8'h80);
    press(8'h02);
    press(8'h39);
    press(sctc_pkg::SC_CTRL_MAKE);
    press(sctc_pkg::SC_CTRL_BREAK);
    press(sctc_pkg::SC_PREFIX);
    press(sctc_pkg::SC_PREFIX);
    press(sctc_pkg::SC_UP);
    press(sctc_pkg::SC_PREFIX);
    press(sctc_pkg::SC_DOWN);
    press(sctc_pkg::SC_PREFIX);
    press(sctc_pkg::SC_CTRL_MAKE);
    press(sctc_pkg::SC_PREFIX);
    press(sctc_pkg::SC_CTRL_BREAK);
    press(sctc_pkg::SC_PREFIX);
    press(8'h10);
    press(sctc_pkg::SC_PREFIX);
    pop_char();
    press(sctc_pkg::SC_DOWN);
    press(8'hC8);
    repeat (4) pop_char();

    // start with a long fill so the queue reaches full early
    kind = FILL;
    span = 700;
    while (sent < ITEM_TARGET) begin
      no_idle  = ($urandom_range(0, 3) == 0);
      read_pct = (kind == FILL) ? 5 : (kind == DRAIN) ? 90 : 50;
      stop     = (sent + span < ITEM_TARGET) ? sent + span : ITEM_TARGET;
      while (sent < stop) begin
        if ($urandom_range(0, 99) < read_pct) pop_char();
        else send_random_scan();
      end
      kind = traffic_t'($urandom_range(0, 2));
      span = $urandom_range(40, 320);
    end
    no_idle = 1'b0;

    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("** scancode_to_char_fifo: PASSED **");
    end else begin
      $display("** scancode_to_char_fifo: FAILED **");
    end
    $finish;
  end

endmodule
